### rtl/core/wnm_pkg.sv
package wnm_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int CHAR_W          = 8;

    localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] QMARK_CHAR = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    // command broadcast from the top level to every cell
    typedef struct packed {
        logic              fire;
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    // only A-Z fold to a-z
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

### rtl/core/wnm_if.sv
interface wnm_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 operation;
    logic [wnm_pkg::CHAR_W-1:0] character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

interface wnm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

### rtl/core/wnm_cell.sv
module wnm_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wnm_pkg::t_cmd i_cmd,
    input  logic          i_prev_used,
    input  logic          i_eps,
    input  logic          i_adv,
    input  logic          i_restart_seed,
    output logic          o_used,
    output logic          o_eps,
    output logic          o_adv,
    output logic          o_is_end,
    output logic          o_end_hit
);
    import wnm_pkg::*;

    logic              r_used, n_used;
    logic              r_seed, n_seed;
    logic [CHAR_W-1:0] r_char, n_char;

    logic act;
    logic is_star;

    // closed activity of this position: own seed or reached over a star to the left
    assign act     = r_seed | i_eps;
    assign is_star = (r_char == STAR_CHAR);

    assign o_used    = r_used;
    assign o_eps     = act & r_used & is_star;
    assign o_adv     = act & r_used & ~is_star &
                       ((r_char == QMARK_CHAR) || (r_char == i_cmd.ch));
    assign o_is_end  = i_prev_used & ~r_used;
    assign o_end_hit = act & o_is_end;

    always_comb begin
        n_used = r_used;
        n_seed = r_seed;
        n_char = r_char;
        if (i_cmd.fire) begin
            case (i_cmd.op)
                OP_CLEAR: begin
                    n_used = 1'b0;
                    n_seed = i_restart_seed;
                end
                OP_APPEND: begin
                    // first free slot takes the character
                    if (i_prev_used && !r_used) begin
                        n_used = 1'b1;
                        n_char = i_cmd.ch;
                    end
                    n_seed = i_restart_seed;
                end
                OP_NAME: begin
                    n_seed = i_adv | o_eps;
                end
                OP_END: begin
                    n_seed = i_restart_seed;
                end
                default: begin
                    n_seed = i_restart_seed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_seed <= i_restart_seed;
        end else begin
            r_used <= n_used;
            r_seed <= n_seed;
        end
        r_char <= n_char;
    end

endmodule

### rtl/core/wildcard_name_matcher_top.sv
// channel  dir  handshake     word
// i_in     in   valid/ready   operation[1:0], character[7:0]
// o_out    out  valid/ready   matched, pattern_overflow
//
// one word per cycle on i_in; every operation finishes in the cycle it is taken
// a result sits in the output register in the cycle after its end-of-name word
// each pattern position is a cell; star closure ripples through the cell row
// i_rst_n is synchronous: empty pattern, no overflow, only position zero active
// i_in.ready drops only while a result waits and o_out.ready is low
module wildcard_name_matcher_top #(
    parameter int PATTERN_MAX = wnm_pkg::PATTERN_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wnm_in_if.sink    i_in,
    wnm_out_if.source o_out
);
    import wnm_pkg::*;

    t_cmd cmd;
    logic in_fire;

    logic [PATTERN_MAX-1:0] used;
    logic [PATTERN_MAX-1:0] eps;
    logic [PATTERN_MAX-1:0] adv;
    logic [PATTERN_MAX-1:0] is_end;
    logic [PATTERN_MAX-1:0] end_hit;

    logic r_tail_seed, n_tail_seed;
    logic r_ovf, n_ovf;
    logic r_out_valid;
    logic r_matched;
    logic r_out_ovf;

    logic tail_end;
    logic match_now;

    assign in_fire    = i_in.valid & i_in.ready;
    assign i_in.ready = ~r_out_valid | o_out.ready;

    assign cmd.fire = in_fire;
    assign cmd.op   = t_op'(i_in.operation);
    assign cmd.ch   = fold_case(i_in.character);

    genvar g;
    generate
        for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
            if (g == 0) begin : g_first
                wnm_cell u_cell (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_cmd          (cmd),
                    .i_prev_used    (1'b1),
                    .i_eps          (1'b0),
                    .i_adv          (1'b0),
                    .i_restart_seed (1'b1),
                    .o_used         (used[g]),
                    .o_eps          (eps[g]),
                    .o_adv          (adv[g]),
                    .o_is_end       (is_end[g]),
                    .o_end_hit      (end_hit[g])
                );
            end else begin : g_rest
                wnm_cell u_cell (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_cmd          (cmd),
                    .i_prev_used    (used[g-1]),
                    .i_eps          (eps[g-1]),
                    .i_adv          (adv[g-1]),
                    .i_restart_seed (1'b0),
                    .o_used         (used[g]),
                    .o_eps          (eps[g]),
                    .o_adv          (adv[g]),
                    .o_is_end       (is_end[g]),
                    .o_end_hit      (end_hit[g])
                );
            end
        end
    endgenerate

    // position after the last cell, reached only by a full pattern
    assign tail_end  = used[PATTERN_MAX-1];
    assign match_now = (|end_hit) | ((r_tail_seed | eps[PATTERN_MAX-1]) & tail_end);

    always_comb begin
        n_tail_seed = r_tail_seed;
        n_ovf       = r_ovf;
        if (in_fire) begin
            case (cmd.op)
                OP_CLEAR: begin
                    n_tail_seed = 1'b0;
                    n_ovf       = 1'b0;
                end
                OP_APPEND: begin
                    n_tail_seed = 1'b0;
                    if (used[PATTERN_MAX-1]) begin
                        n_ovf = 1'b1;
                    end
                end
                OP_NAME: begin
                    n_tail_seed = adv[PATTERN_MAX-1];
                end
                OP_END: begin
                    n_tail_seed = 1'b0;
                end
                default: begin
                    n_tail_seed = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_seed <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tail_seed <= n_tail_seed;
            r_ovf       <= n_ovf;
            if (in_fire && cmd.op == OP_END) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_fire && cmd.op == OP_END) begin
            r_matched <= match_now;
            r_out_ovf <= r_ovf;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_out_ovf;

    // used cells form a contiguous run from cell zero, so exactly one end position
    a_one_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({tail_end, is_end}))
        else $error("pattern end position not unique");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> used[PATTERN_MAX-1])
        else $error("overflow flagged with free pattern storage");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && cmd.op == OP_CLEAR) |=> (used == '0 && !r_ovf))
        else $error("clear left pattern state behind");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_fire && cmd.op == OP_END))
        else $error("result word without end of name");

endmodule
